// File: rtl/bcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and constants of the cross dilation core
// Holds the item structs of both channels, the per-item control flags that
// travel down the pipeline, and the fixed widths and defaults of the block.
// ----------------------------------------------------------------------------
package bcd_pkg;

   // Largest image side the line buffers are built for.
   localparam int MAX_SIDE_DEF = 1024;

   // Pixel width and configuration register width.
   localparam int PIX_W = 8;
   localparam int CSR_W = 11;

   // Image side after reset and smallest legal side.
   localparam int SIDE_RESET = 512;
   localparam int SIDE_MIN   = 3;

   // Foreground pixel value.
   localparam logic [PIX_W-1:0] FG_VALUE = PIX_W'(1);

   // Input item: one pixel or one flush.
   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             flush;
   } bcd_req_type;

   // Result item: one dilated pixel.
   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             last_pixel;
   } bcd_rsp_type;

   // Control flags decided when an item is accepted.
   typedef struct packed {
      logic emit;
      logic interior;
      logic last;
   } bcd_tag_type;

endpackage

// File: rtl/bcd_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_scan: raster position tracking
// Holds the image side, the input and output raster counters, and decides for
// each accepted item whether it advances the frame, emits a result, and
// whether that result is interior or the last one of the frame.
// ----------------------------------------------------------------------------
module bcd_scan #(
   parameter int MAX_SIDE = bcd_pkg::MAX_SIDE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [bcd_pkg::CSR_W-1:0]   csr_wdata,
   input  logic                        accept,
   input  logic                        flush,
   input  logic [bcd_pkg::PIX_W-1:0]   pixel_in,
   output logic                        step,
   output bcd_pkg::bcd_tag_type        tag,
   output logic [$clog2(MAX_SIDE)-1:0] addr,
   output logic [bcd_pkg::PIX_W-1:0]   pixel
);

   localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
   localparam int COL_W     = $clog2(MAX_SIDE);
   localparam int ROW_W     = $clog2(MAX_SIDE + 2);
   localparam int CMP_W     = (SIDE_W > bcd_pkg::CSR_W) ? SIDE_W : bcd_pkg::CSR_W;
   localparam int SIDE_INIT = (bcd_pkg::SIDE_RESET > MAX_SIDE) ? MAX_SIDE
                                                              : bcd_pkg::SIDE_RESET;

   logic [SIDE_W-1:0] side_ff,     side_in;
   logic [COL_W-1:0]  side_max_ff, side_max_in;
   logic [COL_W-1:0]  in_col_ff,   in_col_in;
   logic [ROW_W-1:0]  in_row_ff,   in_row_in;
   logic [COL_W-1:0]  out_col_ff,  out_col_in;
   logic [COL_W-1:0]  out_row_ff,  out_row_in;

   logic [CMP_W-1:0]  wdata_ext;
   logic [SIDE_W-1:0] side_new;
   logic              frame_in;
   logic              emit;
   logic              interior;
   logic              last;

   // Clamp a written side into the supported range.
   always_comb begin
      wdata_ext = CMP_W'(csr_wdata);
      if (wdata_ext < CMP_W'(bcd_pkg::SIDE_MIN)) begin
         side_new = SIDE_W'(bcd_pkg::SIDE_MIN);
      end else if (wdata_ext > CMP_W'(MAX_SIDE)) begin
         side_new = SIDE_W'(MAX_SIDE);
      end else begin
         side_new = SIDE_W'(wdata_ext);
      end
   end

   // Classify the item at the current raster position.
   always_comb begin
      frame_in = (in_row_ff >= ROW_W'(side_ff));
      step     = accept && !(flush && !frame_in);
      pixel    = frame_in ? '0 : pixel_in;
      addr     = in_col_ff;
      // Output starts once one row plus one pixel is buffered.
      emit     = (in_row_ff > ROW_W'(1)) ||
                 ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
      interior = (out_row_ff != '0) && (out_row_ff != side_max_ff) &&
                 (out_col_ff != '0) && (out_col_ff != side_max_ff);
      last     = emit && (out_row_ff == side_max_ff) && (out_col_ff == side_max_ff);
      tag.emit     = emit;
      tag.interior = interior;
      tag.last     = last;
   end

   // Next values of the side and the raster counters.
   always_comb begin
      side_in     = side_ff;
      side_max_in = side_max_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      if (csr_we) begin
         side_in     = side_new;
         side_max_in = COL_W'(side_new - SIDE_W'(1));
         in_col_in   = '0;
         in_row_in   = '0;
         out_col_in  = '0;
         out_row_in  = '0;
      end else if (step) begin
         if (last) begin
            // Frame complete: the next pixel opens a new frame.
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (in_col_ff == side_max_ff) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
            if (emit) begin
               if (out_col_ff == side_max_ff) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + COL_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff     <= SIDE_W'(SIDE_INIT);
         side_max_ff <= COL_W'(SIDE_INIT - 1);
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
      end else begin
         side_ff     <= side_in;
         side_max_ff <= side_max_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
      end
   end

endmodule

// File: rtl/bcd_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_line_buf: two line buffers in one memory
// Each entry holds the pixel of the row above and of the center row for one
// column. One registered read and one write per cycle.
// ----------------------------------------------------------------------------
module bcd_line_buf #(
   parameter int MAX_SIDE = bcd_pkg::MAX_SIDE_DEF
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_SIDE)-1:0]   rd_addr,
   output logic [2*bcd_pkg::PIX_W-1:0]   rd_data,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_SIDE)-1:0]   wr_addr,
   input  logic [2*bcd_pkg::PIX_W-1:0]   wr_data
);

   localparam int DATA_W = 2 * bcd_pkg::PIX_W;

   logic [DATA_W-1:0] mem [MAX_SIDE];
   logic [DATA_W-1:0] rd_data_ff;

   // Registered read; the data holds while no new item is read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Write back the shifted column.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bcd_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_window: neighborhood window, dilation and result register
// Holds the item whose line buffer read is in flight, shifts the cross shaped
// window, computes the dilated pixel and keeps it in the result register.
// ----------------------------------------------------------------------------
module bcd_window #(
   parameter int MAX_SIDE = bcd_pkg::MAX_SIDE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic                          load,
   input  bcd_pkg::bcd_tag_type          tag_in,
   input  logic [$clog2(MAX_SIDE)-1:0]   addr_in,
   input  logic [bcd_pkg::PIX_W-1:0]     pixel_in,
   input  logic [2*bcd_pkg::PIX_W-1:0]   rd_data,
   input  logic                          rsp_stall,
   output logic                          busy,
   output logic                          wr_en,
   output logic [$clog2(MAX_SIDE)-1:0]   wr_addr,
   output logic [2*bcd_pkg::PIX_W-1:0]   wr_data,
   output logic                          rsp_valid,
   output bcd_pkg::bcd_rsp_type          rsp_data
);

   localparam int PW     = bcd_pkg::PIX_W;
   localparam int ADDR_W = $clog2(MAX_SIDE);

   logic                 s1_valid_ff, s1_valid_in;
   bcd_pkg::bcd_tag_type s1_tag_ff,   s1_tag_in;
   logic [ADDR_W-1:0]    s1_addr_ff,  s1_addr_in;
   logic [PW-1:0]        s1_pix_ff,   s1_pix_in;

   logic [PW-1:0] up_ff,     up_in;
   logic [PW-1:0] left_ff,   left_in;
   logic [PW-1:0] center_ff, center_in;
   logic [PW-1:0] right_ff,  right_in;
   logic [PW-1:0] down_ff,   down_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   bcd_pkg::bcd_rsp_type rsp_data_ff,  rsp_data_in;

   logic          out_free;
   logic          s1_go;
   logic [PW-1:0] above_rd;
   logic [PW-1:0] mid_rd;
   logic          hit;
   logic [PW-1:0] result;

   // Stage handshake: an item moves on when it emits no result or its result has a free slot.
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      s1_go    = s1_valid_ff && (!s1_tag_ff.emit || out_free);
      busy     = s1_valid_ff && !s1_go;
   end

   // Cross neighborhood of the center pixel after the shift.
   always_comb begin
      above_rd = rd_data[2*PW-1:PW];
      mid_rd   = rd_data[PW-1:0];
      hit      = (up_ff == bcd_pkg::FG_VALUE) || (center_ff == bcd_pkg::FG_VALUE) ||
                 (mid_rd == bcd_pkg::FG_VALUE) || (down_ff == bcd_pkg::FG_VALUE);
      if (s1_tag_ff.interior && (right_ff != bcd_pkg::FG_VALUE) && hit) begin
         result = bcd_pkg::FG_VALUE;
      end else begin
         result = right_ff;
      end
   end

   // Line buffer write back: the center row moves up, the new pixel enters.
   always_comb begin
      wr_en   = s1_go;
      wr_addr = s1_addr_ff;
      wr_data = {mid_rd, s1_pix_ff};
   end

   // Next values of the stage, the window and the result register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_tag_in   = s1_tag_ff;
      s1_addr_in  = s1_addr_ff;
      s1_pix_in   = s1_pix_ff;
      if (load) begin
         s1_valid_in = 1'b1;
         s1_tag_in   = tag_in;
         s1_addr_in  = addr_in;
         s1_pix_in   = pixel_in;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      up_in     = up_ff;
      left_in   = left_ff;
      center_in = center_ff;
      right_in  = right_ff;
      down_in   = down_ff;
      if (restart || (s1_go && s1_tag_ff.last)) begin
         up_in     = '0;
         left_in   = '0;
         center_in = '0;
         right_in  = '0;
         down_in   = '0;
      end else if (s1_go) begin
         up_in     = above_rd;
         left_in   = center_ff;
         center_in = right_ff;
         right_in  = mid_rd;
         down_in   = s1_pix_ff;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_go && s1_tag_ff.emit) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.pixel_out  = result;
         rsp_data_in.last_pixel = s1_tag_ff.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and window registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         up_ff        <= '0;
         left_ff      <= '0;
         center_ff    <= '0;
         right_ff     <= '0;
         down_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         up_ff        <= up_in;
         left_ff      <= left_in;
         center_ff    <= center_in;
         right_ff     <= right_in;
         down_ff      <= down_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_tag_ff   <= s1_tag_in;
      s1_addr_ff  <= s1_addr_in;
      s1_pix_ff   <= s1_pix_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/binary_cross_dilation_core.sv
`timescale 1ns / 1ps
// Ordering: a result enters the output register as the item that completes its
//    neighborhood leaves the read stage, image_side + 1 items after its pixel.
// Throughput: one item per cycle unless a full result register is stalled,
//    set by the single read and write port pair of the line buffer memory.
// Reset: counters, window and handshake clear, the side returns to 512 (or
//    the maximum side if smaller); line buffer contents are left as they are.
// ----------------------------------------------------------------------------
// binary_cross_dilation_core: streaming 3x3 cross binary dilation
// Takes a square image in raster order, one pixel per item, and returns the
// dilated image in the same order; flush items drain the trailing results.
// ----------------------------------------------------------------------------
module binary_cross_dilation_core #(
   parameter int MAX_SIDE = bcd_pkg::MAX_SIDE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [bcd_pkg::CSR_W-1:0] csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  bcd_pkg::bcd_req_type      req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output bcd_pkg::bcd_rsp_type      rsp_data
);

   localparam int ADDR_W = $clog2(MAX_SIDE);

   logic                          accept;
   logic                          step;
   bcd_pkg::bcd_tag_type          tag;
   logic [ADDR_W-1:0]             addr;
   logic [bcd_pkg::PIX_W-1:0]     pixel;
   logic [2*bcd_pkg::PIX_W-1:0]   rd_data;
   logic                          busy;
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [2*bcd_pkg::PIX_W-1:0]   wr_data;

   // Input handshake: stall only while the held item cannot move on.
   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   bcd_scan #(
      .MAX_SIDE(MAX_SIDE)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .accept   (accept),
      .flush    (req_data.flush),
      .pixel_in (req_data.pixel_in),
      .step     (step),
      .tag      (tag),
      .addr     (addr),
      .pixel    (pixel)
   );

   bcd_line_buf #(
      .MAX_SIDE(MAX_SIDE)
   ) u_line_buf (
      .clock  (clock),
      .rd_en  (step),
      .rd_addr(addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   bcd_window #(
      .MAX_SIDE(MAX_SIDE)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_we),
      .load     (step),
      .tag_in   (tag),
      .addr_in  (addr),
      .pixel_in (pixel),
      .rd_data  (rd_data),
      .rsp_stall(rsp_stall),
      .busy     (busy),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // The input side stalls only behind a full, stalled result register.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the result register could take an item");

   // Every item that reads the line buffer writes its column back.
   assert property (@(posedge clock) disable iff (reset)
      step |=> (wr_en || req_stall))
      else $error("line buffer write back lost for an accepted item");

   // Two frame ends never come out back to back.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_pixel) |=>
         !(rsp_valid && rsp_data.last_pixel))
      else $error("last pixel marked on consecutive items");

endmodule
